FILE: hdl/running_mode_tracker_macros.svh
// Assertion macros used by the checker file of running_mode_tracker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RUNNING_MODE_TRACKER_MACROS_SVH
`define RUNNING_MODE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rmt_pkg.sv
// Shared types and constants of the running mode tracker.
// No dependencies; used by the controller, the datapath and the top level.
package rmt_pkg;

    localparam int DATA_W            = 32;
    localparam int MODE_COUNT_W      = 16;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic search;
        logic update;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic search_end;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/rmt_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module rmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/rmt_ctrl.sv
// Sequencing controller of the running mode tracker.
// Depends on rmt_pkg for the command and status structs.
module rmt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rmt_pkg::dp_status_t status,
    output rmt_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.search_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // The result is committed only once the output register can take it.
                cmd.update = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/rmt_dp.sv
// Datapath of the running mode tracker: table scan, count update, leader and output register.
// Depends on rmt_pkg and instantiates rmt_ram for the key and count table.
module rmt_dp #(
    parameter int TABLE_ENTRIES = rmt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rmt_pkg::COUNT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  rmt_pkg::dp_cmd_t                        cmd,
    output rmt_pkg::dp_status_t                     status,
    input  logic signed [rmt_pkg::DATA_W-1:0]       sample_value,
    input  logic                                    end_of_set,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [rmt_pkg::DATA_W-1:0]       mode_value,
    output logic        [rmt_pkg::MODE_COUNT_W-1:0] mode_count,
    output logic                                    table_overflow,
    output logic                                    set_done
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = rmt_pkg::DATA_W + COUNT_BITS;
    localparam logic [USED_W-1:0]     USED_FULL = USED_W'(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [rmt_pkg::DATA_W-1:0] value_reg;
    logic                       last_reg;
    logic [USED_W-1:0]          used_reg;
    logic [USED_W-1:0]          idx_reg;
    logic                       rd_pend_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       hit_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic [COUNT_BITS-1:0]      cnt_reg;
    logic [rmt_pkg::DATA_W-1:0] leader_value_reg;
    logic [COUNT_BITS-1:0]      leader_count_reg;
    logic                       ovf_reg;
    logic                       out_valid_reg;
    logic [rmt_pkg::DATA_W-1:0] out_value_reg;
    logic [COUNT_BITS-1:0]      out_count_reg;
    logic                       out_ovf_reg;
    logic                       out_done_reg;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_addr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [rmt_pkg::DATA_W-1:0] rd_key;
    logic [COUNT_BITS-1:0]      rd_cnt;

    logic                       hit_now;
    logic                       issue;
    logic                       table_full;
    logic                       do_write;
    logic [COUNT_BITS-1:0]      new_cnt;
    logic [IDX_W-1:0]           wr_slot;
    logic                       take_lead;
    logic [rmt_pkg::DATA_W-1:0] lead_value_upd;
    logic [COUNT_BITS-1:0]      lead_count_upd;
    logic                       ovf_upd;

    rmt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1:COUNT_BITS];
    assign rd_cnt = ram_rdata[COUNT_BITS-1:0];

    // One read is issued per cycle while the scan runs; its data is compared in the cycle after.
    assign hit_now = rd_pend_reg && (rd_key == value_reg);
    assign issue   = cmd.search && (idx_reg != used_reg) && !hit_now;

    assign status.search_end = hit_now || ((idx_reg == used_reg) && !rd_pend_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign table_full = (used_reg == USED_FULL);
    assign do_write   = hit_reg || !table_full;
    assign wr_slot    = hit_reg ? slot_reg : used_reg[IDX_W-1:0];

    always_comb
    begin
        if (!hit_reg)
        begin
            new_cnt = COUNT_BITS'(1);
        end
        else if (cnt_reg == COUNT_MAX)
        begin
            new_cnt = cnt_reg;
        end
        else
        begin
            new_cnt = cnt_reg + COUNT_BITS'(1);
        end
    end

    // A count that only ties the leader does not take the lead.
    assign take_lead      = do_write && (new_cnt > leader_count_reg);
    assign lead_value_upd = take_lead ? value_reg : leader_value_reg;
    assign lead_count_upd = take_lead ? new_cnt : leader_count_reg;
    assign ovf_upd        = ovf_reg | !do_write;

    assign ram_we    = cmd.update && do_write;
    assign ram_addr  = cmd.update ? wr_slot : idx_reg[IDX_W-1:0];
    assign ram_wdata = {value_reg, new_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            idx_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            leader_value_reg <= '0;
            leader_count_reg <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg     <= '0;
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.search)
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + USED_W'(1);
                end
            end

            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    // The set is finished: the table is emptied for the next one.
                    used_reg         <= '0;
                    leader_value_reg <= '0;
                    leader_count_reg <= '0;
                    ovf_reg          <= 1'b0;
                end
                else
                begin
                    if (!hit_reg && !table_full)
                    begin
                        used_reg <= used_reg + USED_W'(1);
                    end
                    leader_value_reg <= lead_value_upd;
                    leader_count_reg <= lead_count_upd;
                    ovf_reg          <= ovf_upd;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= sample_value;
            last_reg  <= end_of_set;
        end
        if (issue)
        begin
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (cmd.search && status.search_end)
        begin
            hit_reg  <= hit_now;
            slot_reg <= rd_idx_reg;
            cnt_reg  <= rd_cnt;
        end
        if (cmd.update)
        begin
            out_value_reg <= lead_value_upd;
            out_count_reg <= lead_count_upd;
            out_ovf_reg   <= ovf_upd;
            out_done_reg  <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_value     = out_value_reg;
    assign mode_count     = rmt_pkg::MODE_COUNT_W'(out_count_reg);
    assign table_overflow = out_ovf_reg;
    assign set_done       = out_done_reg;

endmodule

FILE: hdl/running_mode_tracker.sv
// Top level of the running mode tracker: streaming mode of a set of signed values.
// Depends on rmt_pkg; instantiates rmt_ctrl and rmt_dp.
//
//   channel   | handshake          | fields
//   ----------+--------------------+--------------------------------------------------
//   input     | in_valid, in_stall | sample_value, end_of_set
//   output    | out_valid, out_stall | mode_value, mode_count, table_overflow, set_done
//
// An item's scan grows with the entries it must read: a value new to the set reads every
// entry, a value that matches an entry stops there, and the first value of a set reads
// none. The scan reads the single-port table RAM once per cycle, and a new input is
// taken only after the update of the previous one.
// Reset is asynchronous and active low; the table needs no clearing, as only entries
// below the fill count are read. A stalled result holds in the output register while
// the next transfer on the input side is already taken and scanned.
module running_mode_tracker #(
    parameter int TABLE_ENTRIES = rmt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rmt_pkg::COUNT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [rmt_pkg::DATA_W-1:0]       sample_value,
    input  logic                                    end_of_set,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [rmt_pkg::DATA_W-1:0]       mode_value,
    output logic        [rmt_pkg::MODE_COUNT_W-1:0] mode_count,
    output logic                                    table_overflow,
    output logic                                    set_done
);

    rmt_pkg::dp_cmd_t    cmd;
    rmt_pkg::dp_status_t status;

    rmt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    rmt_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_value  (sample_value),
        .end_of_set    (end_of_set),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode_value    (mode_value),
        .mode_count    (mode_count),
        .table_overflow(table_overflow),
        .set_done      (set_done)
    );

endmodule

FILE: hdl/rmt_checker.sv
// Port-level checker for running_mode_tracker, bound to the top level.
// Depends on rmt_pkg and running_mode_tracker_macros.svh.
`include "running_mode_tracker_macros.svh"

module rmt_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic signed [rmt_pkg::DATA_W-1:0]       sample_value,
    input logic                                    end_of_set,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [rmt_pkg::DATA_W-1:0]       mode_value,
    input logic        [rmt_pkg::MODE_COUNT_W-1:0] mode_count,
    input logic                                    table_overflow,
    input logic                                    set_done
);

    logic                                            in_xfer;
    logic [rmt_pkg::DATA_W+rmt_pkg::MODE_COUNT_W+1:0] out_payload;

    assign in_xfer     = in_valid && !in_stall;
    assign out_payload = {mode_value, mode_count, table_overflow, set_done};

    `RMT_ASSERT_NXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")
    `RMT_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_payload), "stalled result changed")
    // After a transfer in, the block stays busy through at least the scan start and the update.
    `RMT_ASSERT_IMP(a_busy_after_take, in_xfer, ##1 in_stall ##1 in_stall, "input taken while busy")
    // A result cannot appear before the scan and the update of a transfer in are through, when none was pending.
    `RMT_ASSERT_NXT(a_no_early_result, in_xfer && !out_valid, !out_valid ##1 !out_valid, "result too early")

    // The input payload is only watched for unknowns while a transfer happens.
    `RMT_ASSERT_IMP(a_in_known, in_xfer, !$isunknown(sample_value) && !$isunknown(end_of_set), "unknown input payload")

endmodule

bind running_mode_tracker rmt_checker u_rmt_checker (.*);

FILE: tb/sv/tb_running_mode_tracker.sv
`timescale 1ns / 100ps
// Self-checking testbench of running_mode_tracker: a scoreboard keeps its own table of
// distinct values and counts, and each result is checked in order of arrival.
// Depends on rmt_pkg and the running_mode_tracker RTL.
module tb_running_mode_tracker;

    localparam int DATA_W       = rmt_pkg::DATA_W;
    localparam int MODE_COUNT_W = rmt_pkg::MODE_COUNT_W;
    localparam int TABLE_SIZE   = rmt_pkg::TABLE_ENTRIES_DEF;
    localparam int CNT_W        = rmt_pkg::COUNT_BITS_DEF;
    localparam int RUN_LEN      = 30;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic signed [DATA_W-1:0]       value;
        logic        [MODE_COUNT_W-1:0] count;
        logic                           overflow;
        logic                           last;
    } mode_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic signed [DATA_W-1:0]       sample_value;
    logic                           end_of_set;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [DATA_W-1:0]       mode_value;
    logic        [MODE_COUNT_W-1:0] mode_count;
    logic                           table_overflow;
    logic                           set_done;

    // Scoreboard copy of the block's state.
    logic signed [DATA_W-1:0] seen_key   [TABLE_SIZE];
    logic        [CNT_W-1:0]  seen_count [TABLE_SIZE];
    int                       seen_used;
    logic signed [DATA_W-1:0] lead_value;
    logic        [CNT_W-1:0]  lead_count;
    logic                     overflow_flag;

    mode_result_t pending_modes[$];
    int           error_count = 0;
    int           sent_count  = 0;
    bit           quiet       = 1'b0;

    running_mode_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .end_of_set     (end_of_set),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode_value     (mode_value),
        .mode_count     (mode_count),
        .table_overflow (table_overflow),
        .set_done       (set_done)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Counts one value into the scoreboard table and returns the mode it leaves behind.
    function automatic mode_result_t track_sample(input logic signed [DATA_W-1:0] v,
                                                  input logic last);
        mode_result_t     r;
        int               slot;
        logic [CNT_W-1:0] c;
        slot = -1;
        for (int i = 0; i < seen_used; i++)
        begin
            if (seen_key[i] == v)
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0 && seen_used < TABLE_SIZE)
        begin
            slot             = seen_used;
            seen_key[slot]   = v;
            seen_count[slot] = '0;
            seen_used++;
        end
        if (slot >= 0)
        begin
            c = seen_count[slot];
            if (c != '1)
                c = c + 1'b1;
            seen_count[slot] = c;
            // Only a strictly higher count takes the lead.
            if (c > lead_count)
            begin
                lead_count = c;
                lead_value = v;
            end
        end
        else
            overflow_flag = 1'b1;
        r.value    = lead_value;
        r.count    = MODE_COUNT_W'(lead_count);
        r.overflow = overflow_flag;
        r.last     = last;
        if (last)
        begin
            seen_used     = 0;
            lead_value    = '0;
            lead_count    = '0;
            overflow_flag = 1'b0;
        end
        return r;
    endfunction

    // Presents one sample and returns just after the edge at which it is transferred.
    task automatic send_sample(input logic signed [DATA_W-1:0] v, input logic last);
        bit           taken;
        mode_result_t exp_r;
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        end_of_set   <= last;
        exp_r         = track_sample(v, last);
        pending_modes = {pending_modes, exp_r};
        sent_count++;
        // Stall is looked at mid-cycle, where it holds the value the next edge will see.
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic close_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_modes.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin : check_results
        mode_result_t exp_r;
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_modes.size() == 0)
                report_mismatch("result with no sample waiting for it");
            else
            begin
                exp_r = pending_modes.pop_front();
                if (mode_value !== exp_r.value)
                    report_mismatch($sformatf("mode_value %0d, expected %0d",
                                              mode_value, exp_r.value));
                if (mode_count !== exp_r.count)
                    report_mismatch($sformatf("mode_count %0d, expected %0d",
                                              mode_count, exp_r.count));
                if (table_overflow !== exp_r.overflow)
                    report_mismatch($sformatf("table_overflow %b, expected %b",
                                              table_overflow, exp_r.overflow));
                if (set_done !== exp_r.last)
                    report_mismatch($sformatf("set_done %b, expected %b",
                                              set_done, exp_r.last));
            end
        end
    end

    // Extremes of the value range, bit patterns, ties and single-value sets.
    task automatic test_directed();
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sd1, 1'b1);
        // A later value that only draws level must not take over.
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shaaaa_aaaa, 1'b0);
        send_sample(32'shaaaa_aaaa, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'sh5555_5555, 1'b1);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0001, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        close_phase();
    endtask

    // Fills every entry, then offers new values that have no room left, mixed with values already held.
    task automatic test_table_full();
        logic signed [DATA_W-1:0] key;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            if (k == 0)
                key = 32'sh8000_0000;
            else if (k == TABLE_SIZE - 1)
                key = 32'sh7fff_ffff;
            else
                key = k - TABLE_SIZE / 2;
            send_sample(key, 1'b0);
        end
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd12345, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(-32'sd12345, 1'b1);
        // The flag must have cleared with the set.
        send_sample(32'sd12345, 1'b1);
        close_phase();
    endtask

    // Builds a long run of one value; a second value then only draws level with it.
    task automatic test_long_run();
        quiet = 1'b1;
        for (int k = 0; k < RUN_LEN; k++)
            send_sample(32'sh8000_0000, 1'b0);
        for (int k = 0; k < RUN_LEN - 1; k++)
            send_sample(32'sh7fff_ffff, 1'b0);
        send_sample(32'sh7fff_ffff, 1'b1);
        close_phase();
        quiet = 1'b0;
    endtask

    task automatic test_random_sets();
        logic signed [DATA_W-1:0] pool [8];
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] stride;
        int                       pool_size;
        int                       set_len;
        int                       kind;
        int                       start_count;
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS)
        begin
            quiet = (sent_count - start_count >= 200) && (sent_count - start_count < 300);
            kind  = $urandom_range(99);
            if (kind < 8)
            begin
                // More distinct values than entries, with repeats mixed in.
                base    = $urandom;
                stride  = $urandom | 1;
                set_len = TABLE_SIZE + $urandom_range(1, 6);
                for (int k = 0; k < set_len; k++)
                begin
                    send_sample(base + k * stride, 1'b0);
                    if ($urandom_range(9) == 0)
                        send_sample(base + $urandom_range(k) * stride, 1'b0);
                end
                send_sample(base + $urandom_range(set_len) * stride, 1'b1);
            end
            else if (kind < 18)
            begin
                set_len = $urandom_range(1, 4);
                for (int k = 0; k < set_len; k++)
                    send_sample($urandom, k == set_len - 1);
            end
            else
            begin
                pool_size = $urandom_range(1, 8);
                for (int p = 0; p < pool_size; p++)
                begin
                    case ($urandom_range(3))
                        0:       pool[p] = $urandom_range(8) - 4;
                        1:       pool[p] = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                        default: pool[p] = $urandom;
                    endcase
                end
                set_len = $urandom_range(1, 24);
                for (int k = 0; k < set_len; k++)
                    send_sample(pool[$urandom_range(pool_size - 1)], k == set_len - 1);
            end
        end
        quiet = 1'b0;
        close_phase();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        sample_value <= '0;
        end_of_set   <= 1'b0;
        seen_used     = 0;
        lead_value    = '0;
        lead_count    = '0;
        overflow_flag = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_long_run();
        test_random_sets();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_modes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_modes.size()));
        if (error_count == 0)
            $display("[running_mode_tracker] OK");
        else
            $display("[running_mode_tracker] ERROR");
        $finish;
    end

    // A correct run ends well before this timeout, even with every item scanning a full table.
    initial
    begin
        #(5_000_000);
        $display("[running_mode_tracker] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rmt_pkg.sv
hdl/rmt_ram.sv
hdl/rmt_ctrl.sv
hdl/rmt_dp.sv
hdl/running_mode_tracker.sv
hdl/rmt_checker.sv
tb/sv/tb_running_mode_tracker.sv
